[sv/mp2d_pkg.sv]
package mp2d_pkg;

	localparam int MAX_COLS_DEF   = 2048;
	localparam int MAX_WINDOW_DEF = 8;
	localparam int PIXEL_BITS_DEF = 16;

	localparam int CFG_W     = 12;    // widest configuration register
	localparam int IDX_W     = 11;    // output row / column index
	localparam int IW        = 13;    // internal coordinate arithmetic
	localparam int ROW_LIMIT = 2048;
	localparam int STRIDE_MAX = 15;

	localparam logic [1:0] REG_ROWS   = 2'd0;
	localparam logic [1:0] REG_COLS   = 2'd1;
	localparam logic [1:0] REG_WIN    = 2'd2;
	localparam logic [1:0] REG_STRIDE = 2'd3;

	// zero acts as one, large values saturate at hi
	function automatic logic [IW-1:0] clamp_cfg(input logic [CFG_W-1:0] v,
		input logic [IW-1:0] hi);
		logic [IW-1:0] ext;
		ext = IW'(v);
		if (v == '0) begin
			return IW'(1);
		end else if (ext > hi) begin
			return hi;
		end
		return ext;
	endfunction

endpackage

[sv/mp2d_colbuf.sv]
module mp2d_colbuf #(
	parameter int MAX_COLS   = mp2d_pkg::MAX_COLS_DEF,
	parameter int MAX_WINDOW = mp2d_pkg::MAX_WINDOW_DEF,
	parameter int PIXEL_BITS = mp2d_pkg::PIXEL_BITS_DEF,
	parameter int AW         = $clog2(MAX_COLS)
) (
	input  logic                                   clk,
	input  logic                                   load,
	input  logic [AW-1:0]                          addr,
	input  logic [PIXEL_BITS-1:0]                  pixel,
	input  logic                                   commit,
	output logic [MAX_WINDOW-1:0][PIXEL_BITS-1:0] vmax
);
	import mp2d_pkg::*;

	localparam int HW = MAX_WINDOW - 1;

	// one word per column: the pixels of the HW rows above, newest in slot 0
	typedef logic [HW-1:0][PIXEL_BITS-1:0] hist_t;

	hist_t                 mem [MAX_COLS];
	hist_t                 rd_q;
	hist_t                 wr_word;
	logic [AW-1:0]         addr_q;
	logic [PIXEL_BITS-1:0] pix_q;

	always_ff @(posedge clk) begin
		if (load) begin
			rd_q   <= mem[addr];
			addr_q <= addr;
			pix_q  <= pixel;
		end
		if (commit) begin
			mem[addr_q] <= wr_word;
		end
	end

	always_comb begin
		wr_word[0] = pix_q;
		for (int i = 1; i < HW; i++) begin
			wr_word[i] = rd_q[i-1];
		end
		// vmax[d]: max of the d+1 lowest rows of this column
		vmax[0] = pix_q;
		for (int i = 1; i < MAX_WINDOW; i++) begin
			vmax[i] = (rd_q[i-1] > vmax[i-1]) ? rd_q[i-1] : vmax[i-1];
		end
	end

endmodule

[sv/mp2d_cell.sv]
module mp2d_cell #(
	parameter int MAX_WINDOW = mp2d_pkg::MAX_WINDOW_DEF,
	parameter int PIXEL_BITS = mp2d_pkg::PIXEL_BITS_DEF,
	parameter int DW         = $clog2(MAX_WINDOW)
) (
	input  logic                                   clk,
	input  logic                                   shift,
	input  logic [MAX_WINDOW-1:0][PIXEL_BITS-1:0] col_in,
	output logic [MAX_WINDOW-1:0][PIXEL_BITS-1:0] col_out,
	input  logic [DW-1:0]                          dsel,
	input  logic                                   take,
	input  logic [PIXEL_BITS-1:0]                  acc_in,
	output logic [PIXEL_BITS-1:0]                  acc_out
);
	import mp2d_pkg::*;

	logic [MAX_WINDOW-1:0][PIXEL_BITS-1:0] col_q;
	logic [PIXEL_BITS-1:0]                 sel;

	always_ff @(posedge clk) begin
		if (shift) begin
			col_q <= col_in;
		end
	end

	assign col_out = col_q;
	assign sel     = col_q[dsel];
	assign acc_out = (take && sel > acc_in) ? sel : acc_in;

endmodule

[sv/max_pooling_2d_stream_core.sv]
// channel | dir | tdata (low bit up)                  | tuser      | tlast
// s_axis  | in  | pixel                               | -          | -
// m_axis  | out | max_value, out_row, out_col, pad    | image_done | last_of_run
// cfg     | in  | cfg_we, cfg_index, cfg_wdata (write only, no handshake)
//
// A pixel is accepted, updates its column, searches its window origins, then
// emits each result it completes (up to 64) as m_axis accepts them, each result
// formed through the row of MAX_WINDOW max cells.
// Output register decouples m_axis: the next pixel is taken while a result waits.
// Async active-low reset clears config to rows 1, cols 1, window 2, stride 1.
// The line store is not cleared; only entries written in the current image are used.
module max_pooling_2d_stream_core #(
	parameter int MAX_COLS   = mp2d_pkg::MAX_COLS_DEF,
	parameter int MAX_WINDOW = mp2d_pkg::MAX_WINDOW_DEF,
	parameter int PIXEL_BITS = mp2d_pkg::PIXEL_BITS_DEF
) (
	input  logic                                        clk,
	input  logic                                        arst_n,
	input  logic                                        s_axis_tvalid,
	output logic                                        s_axis_tready,
	input  logic [((PIXEL_BITS+7)/8)*8-1:0]             s_axis_tdata,  // pixel
	output logic                                        m_axis_tvalid,
	input  logic                                        m_axis_tready,
	// max_value, out_row, out_col, zero pad
	output logic [((PIXEL_BITS+2*mp2d_pkg::IDX_W+7)/8)*8-1:0] m_axis_tdata,
	output logic                                        m_axis_tlast,
	output logic                                        m_axis_tuser,  // image_done
	input  logic                                        cfg_we,
	input  logic [1:0]                                  cfg_index,
	input  logic [mp2d_pkg::CFG_W-1:0]                  cfg_wdata
);
	import mp2d_pkg::*;

	localparam int CW  = $clog2(MAX_COLS);
	localparam int DW  = $clog2(MAX_WINDOW);
	localparam int TDO = ((PIXEL_BITS + 2*IDX_W + 7) / 8) * 8;

	typedef enum logic [1:0] {ST_IDLE, ST_COL, ST_FIND, ST_EMIT} state_t;
	typedef logic [MAX_WINDOW-1:0][PIXEL_BITS-1:0] vec_t;

	state_t state_q;

	logic [CFG_W-1:0] rows_q, cols_q;
	logic [3:0]       win_q, stride_q;
	logic [IW-1:0]    rows_eff, cols_eff, win_eff, s_eff;

	logic [IDX_W-1:0] row_q, rq_q, cq_q;
	logic [CW-1:0]    col_q;
	logic [3:0]       rph_q, cph_q;

	logic [IW-1:0]    r_s1, c_s1, rtop_s1, ctop_s1;
	logic [IDX_W-1:0] rti_s1, cti_s1;
	logic             lastr_s1, lastc_s1;

	logic [IW-1:0]    rlo_q, rhi_q, clo_q, chi_q, rcur_q, ccur_q, ce_q;
	logic [IDX_W-1:0] ridx_q, cidx_q, cie_q;
	logic             rempty_q, cempty_q;

	logic             m_valid_q, m_last_q, m_user_q;
	logic [TDO-1:0]   m_data_q;

	logic             in_fire, last_row, last_col, rstep, cstep, none, out_load;
	logic             colend, rowend;
	logic [IW-1:0]    rlo_w, clo_w, r1, c1;
	logic [IW-1:0]    dsel_w, jm1_w;
	logic [DW-1:0]    dsel;
	logic [DW-1:0]    jm1;
	vec_t             vmax;
	vec_t             colv [MAX_WINDOW];
	logic [PIXEL_BITS-1:0] acc [MAX_WINDOW+1];
	logic [MAX_WINDOW-1:0] take;

	assign rows_eff = clamp_cfg(rows_q, IW'(ROW_LIMIT));
	assign cols_eff = clamp_cfg(cols_q, IW'(MAX_COLS));
	assign win_eff  = clamp_cfg(CFG_W'(win_q), IW'(MAX_WINDOW));
	assign s_eff    = clamp_cfg(CFG_W'(stride_q), IW'(STRIDE_MAX));

	assign s_axis_tready = (state_q == ST_IDLE);
	assign in_fire       = s_axis_tvalid && s_axis_tready;
	assign last_row      = (IW'(row_q) == rows_eff - IW'(1));
	assign last_col      = (IW'(col_q) == cols_eff - IW'(1));

	assign r1    = r_s1 + IW'(1);
	assign c1    = c_s1 + IW'(1);
	assign rlo_w = (r1 >= win_eff) ? r1 - win_eff : '0;
	assign clo_w = (c1 >= win_eff) ? c1 - win_eff : '0;

	assign rstep = (rcur_q >= rlo_q + s_eff);
	assign cstep = (ccur_q >= clo_q + s_eff);
	assign none  = rempty_q || cempty_q || (rcur_q < rlo_q) || (rcur_q > rhi_q)
		|| (ccur_q < clo_q) || (ccur_q > chi_q);

	assign colend   = (ce_q + s_eff > chi_q);
	assign rowend   = (rcur_q + s_eff > rhi_q);
	assign out_load = (state_q == ST_EMIT) && (!m_valid_q || m_axis_tready);

	// window depth and width, less one
	assign dsel_w = r_s1 - rcur_q;
	assign jm1_w  = c_s1 - ce_q;
	assign dsel   = dsel_w[DW-1:0];
	assign jm1    = jm1_w[DW-1:0];

	mp2d_colbuf #(
		.MAX_COLS(MAX_COLS), .MAX_WINDOW(MAX_WINDOW), .PIXEL_BITS(PIXEL_BITS), .AW(CW)
	) u_colbuf (
		.clk(clk),
		.load(in_fire),
		.addr(col_q),
		.pixel(s_axis_tdata[PIXEL_BITS-1:0]),
		.commit(state_q == ST_COL),
		.vmax(vmax)
	);

	// cell k holds the column maxima of column c-k
	assign acc[0] = '0;
	for (genvar k = 0; k < MAX_WINDOW; k++) begin : g_cell
		assign take[k] = (DW'(k) <= jm1);
		if (k == 0) begin : g_head
			mp2d_cell #(.MAX_WINDOW(MAX_WINDOW), .PIXEL_BITS(PIXEL_BITS), .DW(DW)) u_cell (
				.clk(clk), .shift(state_q == ST_COL), .col_in(vmax), .col_out(colv[k]),
				.dsel(dsel), .take(take[k]), .acc_in(acc[k]), .acc_out(acc[k+1])
			);
		end else begin : g_body
			mp2d_cell #(.MAX_WINDOW(MAX_WINDOW), .PIXEL_BITS(PIXEL_BITS), .DW(DW)) u_cell (
				.clk(clk), .shift(state_q == ST_COL), .col_in(colv[k-1]), .col_out(colv[k]),
				.dsel(dsel), .take(take[k]), .acc_in(acc[k]), .acc_out(acc[k+1])
			);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			rows_q    <= CFG_W'(1);
			cols_q    <= CFG_W'(1);
			win_q     <= 4'd2;
			stride_q  <= 4'd1;
			row_q     <= '0;
			col_q     <= '0;
			rph_q     <= '0;
			cph_q     <= '0;
			rq_q      <= '0;
			cq_q      <= '0;
			r_s1      <= '0;
			c_s1      <= '0;
			rtop_s1   <= '0;
			ctop_s1   <= '0;
			rti_s1    <= '0;
			cti_s1    <= '0;
			lastr_s1  <= 1'b0;
			lastc_s1  <= 1'b0;
			rlo_q     <= '0;
			rhi_q     <= '0;
			clo_q     <= '0;
			chi_q     <= '0;
			rcur_q    <= '0;
			ccur_q    <= '0;
			ce_q      <= '0;
			ridx_q    <= '0;
			cidx_q    <= '0;
			cie_q     <= '0;
			rempty_q  <= 1'b0;
			cempty_q  <= 1'b0;
			m_valid_q <= 1'b0;
			m_last_q  <= 1'b0;
			m_user_q  <= 1'b0;
			m_data_q  <= '0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_ROWS:   rows_q   <= cfg_wdata;
					REG_COLS:   cols_q   <= cfg_wdata;
					REG_WIN:    win_q    <= cfg_wdata[3:0];
					REG_STRIDE: stride_q <= cfg_wdata[3:0];
					default:    rows_q   <= rows_q;
				endcase
				row_q <= '0;
				col_q <= '0;
				rph_q <= '0;
				cph_q <= '0;
				rq_q  <= '0;
				cq_q  <= '0;
			end else if (in_fire) begin
				if (last_col) begin
					col_q <= '0;
					cph_q <= '0;
					cq_q  <= '0;
					if (last_row) begin
						row_q <= '0;
						rph_q <= '0;
						rq_q  <= '0;
					end else begin
						row_q <= row_q + IDX_W'(1);
						if (IW'(rph_q) + IW'(1) == s_eff) begin
							rph_q <= '0;
							rq_q  <= rq_q + IDX_W'(1);
						end else begin
							rph_q <= rph_q + 4'd1;
						end
					end
				end else begin
					col_q <= col_q + CW'(1);
					if (IW'(cph_q) + IW'(1) == s_eff) begin
						cph_q <= '0;
						cq_q  <= cq_q + IDX_W'(1);
					end else begin
						cph_q <= cph_q + 4'd1;
					end
				end
			end

			if (out_load) begin
				m_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				m_valid_q <= 1'b0;
			end

			case (state_q)
				ST_IDLE: begin
					if (in_fire) begin
						r_s1     <= IW'(row_q);
						c_s1     <= IW'(col_q);
						lastr_s1 <= last_row;
						lastc_s1 <= last_col;
						rtop_s1  <= IW'(row_q) - IW'(rph_q);
						ctop_s1  <= IW'(col_q) - IW'(cph_q);
						rti_s1   <= rq_q;
						cti_s1   <= cq_q;
						state_q  <= ST_COL;
					end
				end
				ST_COL: begin
					// start at the highest stride multiple not past the pixel
					rlo_q    <= rlo_w;
					rhi_q    <= lastr_s1 ? r_s1 : rlo_w;
					rempty_q <= (r1 < win_eff) && !lastr_s1;
					clo_q    <= clo_w;
					chi_q    <= lastc_s1 ? c_s1 : clo_w;
					cempty_q <= (c1 < win_eff) && !lastc_s1;
					rcur_q   <= rtop_s1;
					ridx_q   <= rti_s1;
					ccur_q   <= ctop_s1;
					cidx_q   <= cti_s1;
					state_q  <= ST_FIND;
				end
				ST_FIND: begin
					if (rstep) begin
						rcur_q <= rcur_q - s_eff;
						ridx_q <= ridx_q - IDX_W'(1);
					end
					if (cstep) begin
						ccur_q <= ccur_q - s_eff;
						cidx_q <= cidx_q - IDX_W'(1);
					end
					if (!rstep && !cstep) begin
						ce_q    <= ccur_q;
						cie_q   <= cidx_q;
						state_q <= none ? ST_IDLE : ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (out_load) begin
						m_data_q <= TDO'({cie_q, ridx_q, acc[MAX_WINDOW]});
						m_last_q <= colend && rowend;
						m_user_q <= colend && rowend && lastr_s1 && lastc_s1;
						if (colend) begin
							ce_q   <= ccur_q;
							cie_q  <= cidx_q;
							rcur_q <= rcur_q + s_eff;
							ridx_q <= ridx_q + IDX_W'(1);
						end else begin
							ce_q  <= ce_q + s_eff;
							cie_q <= cie_q + IDX_W'(1);
						end
						if (colend && rowend) begin
							state_q <= ST_IDLE;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = m_data_q;
	assign m_axis_tlast  = m_last_q;
	assign m_axis_tuser  = m_user_q;

	a_done_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser |-> m_axis_tlast)
		else $error("image_done without last_of_run");

	a_depth_in_cells: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_EMIT |-> (rcur_q <= r_s1) && (dsel_w < IW'(MAX_WINDOW)))
		else $error("window depth outside column buffer");

	a_width_in_cells: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_EMIT |-> (ce_q <= c_s1) && (jm1_w < IW'(MAX_WINDOW)))
		else $error("window width outside cell row");

	a_accept_to_col: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire && !cfg_we |=> state_q == ST_COL)
		else $error("accepted pixel did not reach column update");

endmodule
